// ===== sv/etm_pkg.sv =====
// shared types, constants and fixed-point helpers for the euler transform matrix core
// no dependencies
`default_nettype none
package etm_pkg;

  localparam int TRIG_FRAC = 30;
  localparam int TRIG_W    = 32;
  localparam int ROT_W     = 34;
  localparam int FAC_W     = 32;
  localparam int ENTRY_W   = 32;
  localparam int PROD_W    = ROT_W + FAC_W;
  localparam int SCALE_W   = 16;
  localparam int POS_W     = 32;

  // quarter-wave sine polynomial coefficients, q30
  localparam logic [30:0] POLY_A = 31'd1686629713;
  localparam logic [29:0] POLY_B = 30'd688904866;
  localparam logic [26:0] POLY_C = 27'd76016977;

  localparam logic [1:0] COL_POS         = 2'd3;
  localparam logic [1:0] COL_LAST_NORMAL = 2'd2;
  localparam logic       MODE_NORMAL     = 1'b1;
  localparam logic [1:0] ITEM_GAP        = 2'd3;

  localparam logic [ENTRY_W-1:0] ENTRY_MAX = 32'h7fff_ffff;
  localparam logic [ENTRY_W-1:0] ENTRY_MIN = 32'h8000_0000;

  typedef logic signed [ROT_W-1:0] rot_e_t;
  typedef rot_e_t [2:0][2:0] rot_t;

  typedef struct packed {
    logic                     mode;
    logic [2:0][SCALE_W-1:0]  scale;
    logic [2:0][POS_W-1:0]    pos;
  } ctx_t;

  typedef struct packed {
    logic               neg;
    logic               zero;
    logic [SCALE_W-1:0] dvs;
    logic [SCALE_W-1:0] rem;
  } div_t;

  // floor(a * b / 2^30)
  function automatic rot_e_t mq(input rot_e_t a, input rot_e_t b);
    logic signed [2*ROT_W-1:0] p;
    p = a * b;
    return p[TRIG_FRAC +: ROT_W];
  endfunction

endpackage
`default_nettype wire

// ===== sv/etm_trig.sv =====
// pipelined quarter-wave sine of one binary angle, q2.30 result
// depends on etm_pkg
`default_nettype none
module etm_trig import etm_pkg::*; #(
  parameter int ANGLE_BITS = 16
) (
  input  wire logic                     clk,
  input  wire logic [ANGLE_BITS-1:0]    angle,
  output logic signed [TRIG_W-1:0]      value
);

  localparam int REM_BITS = ANGLE_BITS - 2;
  localparam logic [30:0] ONE = 31'd1 << TRIG_FRAC;

  logic [30:0] x_nxt;
  logic [30:0] x1_r, x2_r, sq2_r, x3_r, sq3_r, x4_r;
  logic [29:0] t3_r;
  logic [30:0] t4_r;
  logic        n1_r, n2_r, n3_r, n4_r;
  logic [TRIG_W-1:0] value_r;
  logic [61:0] p2;
  logic [57:0] p3;
  logic [60:0] p4;
  logic [61:0] p5;

  always_comb begin
    x_nxt = 31'(angle[REM_BITS-1:0]) << (TRIG_FRAC - REM_BITS);
    if (angle[ANGLE_BITS-2]) begin
      x_nxt = ONE - x_nxt;
    end
    p2 = 62'(x1_r) * 62'(x1_r);
    p3 = 58'(POLY_C) * 58'(sq2_r);
    p4 = 61'(t3_r) * 61'(sq3_r);
    p5 = 62'(t4_r) * 62'(x4_r);
  end

  always_ff @(posedge clk) begin
    x1_r  <= x_nxt;
    n1_r  <= angle[ANGLE_BITS-1];
    sq2_r <= p2[TRIG_FRAC +: 31];
    x2_r  <= x1_r;
    n2_r  <= n1_r;
    t3_r  <= POLY_B - 30'(p3[57:TRIG_FRAC]);
    sq3_r <= sq2_r;
    x3_r  <= x2_r;
    n3_r  <= n2_r;
    t4_r  <= POLY_A - p4[60:TRIG_FRAC];
    x4_r  <= x3_r;
    n4_r  <= n3_r;
    value_r <= n4_r ? (32'd0 - p5[61:TRIG_FRAC]) : p5[61:TRIG_FRAC];
  end

  assign value = $signed(value_r);

endmodule
`default_nettype wire

// ===== sv/etm_rot.sv =====
// two-stage y-x-z rotation matrix from three sine/cosine pairs
// depends on etm_pkg
`default_nettype none
module etm_rot import etm_pkg::*; (
  input  wire logic                     clk,
  input  wire logic signed [TRIG_W-1:0] c1,
  input  wire logic signed [TRIG_W-1:0] s1,
  input  wire logic signed [TRIG_W-1:0] c2,
  input  wire logic signed [TRIG_W-1:0] s2,
  input  wire logic signed [TRIG_W-1:0] c3,
  input  wire logic signed [TRIG_W-1:0] s3,
  output rot_t                          rot
);

  rot_e_t ec1, es1, ec2, es2, ec3, es3;
  rot_e_t p12_r, q12_r, m_c1c3_r, m_c2s3_r, m_c3s1_r, m_c1s3_r;
  rot_e_t m_c2c3_r, m_s1s3_r, m_c2s1_r, m_c1c2_r, ns2_r, c3_r, s3_r;
  rot_t   rot_r;

  assign ec1 = ROT_W'(c1);
  assign es1 = ROT_W'(s1);
  assign ec2 = ROT_W'(c2);
  assign es2 = ROT_W'(s2);
  assign ec3 = ROT_W'(c3);
  assign es3 = ROT_W'(s3);

  always_ff @(posedge clk) begin
    p12_r    <= mq(es1, es2);
    q12_r    <= mq(ec1, es2);
    m_c1c3_r <= mq(ec1, ec3);
    m_c2s3_r <= mq(ec2, es3);
    m_c3s1_r <= mq(ec3, es1);
    m_c1s3_r <= mq(ec1, es3);
    m_c2c3_r <= mq(ec2, ec3);
    m_s1s3_r <= mq(es1, es3);
    m_c2s1_r <= mq(ec2, es1);
    m_c1c2_r <= mq(ec1, ec2);
    ns2_r    <= -es2;
    c3_r     <= ec3;
    s3_r     <= es3;

    rot_r[0][0] <= m_c1c3_r + mq(p12_r, s3_r);
    rot_r[0][1] <= m_c2s3_r;
    rot_r[0][2] <= mq(q12_r, s3_r) - m_c3s1_r;
    rot_r[1][0] <= mq(p12_r, c3_r) - m_c1s3_r;
    rot_r[1][1] <= m_c2c3_r;
    rot_r[1][2] <= mq(q12_r, c3_r) + m_s1s3_r;
    rot_r[2][0] <= m_c2s1_r;
    rot_r[2][1] <= ns2_r;
    rot_r[2][2] <= m_c1c2_r;
  end

  assign rot = rot_r;

endmodule
`default_nettype wire

// ===== sv/etm_div_cell.sv =====
// one restoring-division cell: settles one reciprocal quotient bit per cycle
// depends on etm_pkg
`default_nettype none
module etm_div_cell import etm_pkg::*; #(
  parameter int Q_BITS = 25
) (
  input  wire logic              clk,
  input  wire div_t              d_i,
  input  wire logic [Q_BITS-1:0] q_i,
  input  wire logic              num_bit,
  output div_t                   d_o,
  output logic [Q_BITS-1:0]      q_o
);

  logic [SCALE_W:0]   trial, diff;
  logic               ge;
  div_t               cell_nxt;
  div_t               cell_r;
  logic [Q_BITS-1:0]  q_nxt, q_r;

  always_comb begin
    trial    = {d_i.rem, num_bit};
    diff     = trial - {1'b0, d_i.dvs};
    ge       = trial >= {1'b0, d_i.dvs};
    cell_nxt = d_i;
    cell_nxt.rem = ge ? diff[SCALE_W-1:0] : trial[SCALE_W-1:0];
    q_nxt    = {q_i[Q_BITS-2:0], ge};
  end

  always_ff @(posedge clk) begin
    cell_r <= cell_nxt;
    q_r    <= q_nxt;
  end

  assign d_o = cell_r;
  assign q_o = q_r;

endmodule
`default_nettype wire

// ===== sv/etm_delay.sv =====
// fixed-length register delay line used to line up side data with the divider
// no dependencies
`default_nettype none
module etm_delay #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1
) (
  input  wire logic             clk,
  input  wire logic [WIDTH-1:0] d_i,
  output logic [WIDTH-1:0]      d_o
);

  logic [WIDTH-1:0] line_r [DEPTH];

  always_ff @(posedge clk) begin
    line_r[0] <= d_i;
    for (int i = 1; i < DEPTH; i++) begin
      line_r[i] <= line_r[i-1];
    end
  end

  assign d_o = line_r[DEPTH-1];

endmodule
`default_nettype wire

// ===== sv/euler_transform_matrix_core.sv =====
// top level of the euler transform matrix core: trig, rotation, reciprocal chain, column output
// depends on etm_pkg, etm_trig, etm_rot, etm_div_cell, etm_delay
`default_nettype none
// An item (mode, three binary angles, Q8.8 scale, position) transfers on a clock edge with
// start high and busy low. busy then stays high until the ITEM_GAP counter has run down, and
// the result port moves one matrix column per cycle. The first column of an item appears once
// it has passed the reciprocal divider, a row of FRAC_BITS + 9 cells, one quotient bit per
// cell, per scale axis, and then the column sequencer, product and output registers. Columns
// of one item then follow on consecutive cycles: four in model mode (the last one being the
// position with w = 1.0), three in normal mode. Each column is on the out_ ports for exactly
// one cycle with out_valid high; the receiver cannot stall, so it must take every column.
module euler_transform_matrix_core import etm_pkg::*; #(
  parameter int ANGLE_BITS = 16,
  parameter int FRAC_BITS  = 16
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  output logic                           busy,
  input  wire logic                      in_mode,
  input  wire logic [ANGLE_BITS-1:0]     in_angle_x,
  input  wire logic [ANGLE_BITS-1:0]     in_angle_y,
  input  wire logic [ANGLE_BITS-1:0]     in_angle_z,
  input  wire logic signed [SCALE_W-1:0] in_scale_x,
  input  wire logic signed [SCALE_W-1:0] in_scale_y,
  input  wire logic signed [SCALE_W-1:0] in_scale_z,
  input  wire logic signed [POS_W-1:0]   in_pos_x,
  input  wire logic signed [POS_W-1:0]   in_pos_y,
  input  wire logic signed [POS_W-1:0]   in_pos_z,
  output logic                           out_valid,
  output logic [1:0]                     out_column_index,
  output logic signed [ENTRY_W-1:0]      out_entry_0,
  output logic signed [ENTRY_W-1:0]      out_entry_1,
  output logic signed [ENTRY_W-1:0]      out_entry_2,
  output logic signed [ENTRY_W-1:0]      out_entry_3,
  output logic                           out_last_column
);

  // divider length and pipeline alignment
  localparam int Q_BITS   = FRAC_BITS + 9;
  localparam int TRIG_LAT = 5;
  localparam int ROT_LAT  = 2;
  localparam int ROT_DLY  = Q_BITS - TRIG_LAT - ROT_LAT;
  localparam int MODEL_SH = 38 - FRAC_BITS;
  localparam logic [ANGLE_BITS-1:0] QUARTER = ANGLE_BITS'(1) << (ANGLE_BITS - 2);
  localparam logic [ENTRY_W-1:0] W_ONE = ENTRY_W'(1) << FRAC_BITS;

  // input transfer and spacing
  logic       accept;
  logic [1:0] gap_r, gap_nxt;

  assign accept = start & ~busy;
  assign busy   = (gap_r != 2'd0);

  always_comb begin
    gap_nxt = gap_r;
    if (accept) begin
      gap_nxt = ITEM_GAP;
    end else if (gap_r != 2'd0) begin
      gap_nxt = gap_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gap_r <= 2'd0;
    end else begin
      gap_r <= gap_nxt;
    end
  end

  // sines and cosines: y gives c1/s1, x gives c2/s2, z gives c3/s3
  logic signed [TRIG_W-1:0] c1, s1, c2, s2, c3, s3;

  etm_trig #(.ANGLE_BITS(ANGLE_BITS)) u_sin_y (.clk, .angle(in_angle_y), .value(s1));
  etm_trig #(.ANGLE_BITS(ANGLE_BITS)) u_cos_y (.clk, .angle(in_angle_y + QUARTER), .value(c1));
  etm_trig #(.ANGLE_BITS(ANGLE_BITS)) u_sin_x (.clk, .angle(in_angle_x), .value(s2));
  etm_trig #(.ANGLE_BITS(ANGLE_BITS)) u_cos_x (.clk, .angle(in_angle_x + QUARTER), .value(c2));
  etm_trig #(.ANGLE_BITS(ANGLE_BITS)) u_sin_z (.clk, .angle(in_angle_z), .value(s3));
  etm_trig #(.ANGLE_BITS(ANGLE_BITS)) u_cos_z (.clk, .angle(in_angle_z + QUARTER), .value(c3));

  rot_t rot_w, rot_a;

  etm_rot u_rot (.clk, .c1, .s1, .c2, .s2, .c3, .s3, .rot(rot_w));

  // hold the rotation until the reciprocals come out of the divider row
  etm_delay #(.WIDTH($bits(rot_t)), .DEPTH(ROT_DLY)) u_rot_dly (
    .clk, .d_i(rot_w), .d_o(rot_a)
  );

  // mode, scale and position ride alongside the divider row
  ctx_t ctx_in, ctx_a;

  always_comb begin
    ctx_in.mode  = in_mode;
    ctx_in.scale = {in_scale_z, in_scale_y, in_scale_x};
    ctx_in.pos   = {in_pos_z, in_pos_y, in_pos_x};
  end

  etm_delay #(.WIDTH($bits(ctx_t)), .DEPTH(Q_BITS)) u_ctx_dly (
    .clk, .d_i(ctx_in), .d_o(ctx_a)
  );

  // transfer marker follows the same path length
  logic [Q_BITS-1:0] vld_r;
  logic              align_v;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[Q_BITS-2:0], accept};
    end
  end

  assign align_v = vld_r[Q_BITS-1];

  // reciprocal of each scale: 2^(FRAC_BITS+8) / |scale|, one bit per cell
  function automatic logic [FAC_W-1:0] recip_of(input div_t d, input logic [Q_BITS-1:0] q);
    logic [63:0] q64;
    logic [FAC_W-1:0] r;
    q64 = 64'(q);
    if (d.zero) begin
      r = ENTRY_MAX;
    end else if (!d.neg) begin
      r = (q64 > 64'h7fff_ffff) ? ENTRY_MAX : q64[FAC_W-1:0];
    end else begin
      r = (q64 > 64'h8000_0000) ? ENTRY_MIN : (32'd0 - q64[FAC_W-1:0]);
    end
    return r;
  endfunction

  div_t              dc    [3][Q_BITS+1];
  logic [Q_BITS-1:0] qc    [3][Q_BITS+1];
  logic [FAC_W-1:0]  recip [3];

  for (genvar k = 0; k < 3; k++) begin : g_lane
    logic [SCALE_W-1:0] sc;
    logic [SCALE_W-1:0] smag;

    assign sc   = ctx_in.scale[k];
    assign smag = sc[SCALE_W-1] ? (SCALE_W'(0) - sc) : sc;
    assign dc[k][0] = '{neg: sc[SCALE_W-1], zero: (sc == '0), dvs: smag, rem: '0};
    assign qc[k][0] = '0;

    for (genvar j = 0; j < Q_BITS; j++) begin : g_cell
      etm_div_cell #(.Q_BITS(Q_BITS)) u_cell (
        .clk,
        .d_i    (dc[k][j]),
        .q_i    (qc[k][j]),
        .num_bit(j == 0),
        .d_o    (dc[k][j+1]),
        .q_o    (qc[k][j+1])
      );
    end

    assign recip[k] = recip_of(dc[k][Q_BITS], qc[k][Q_BITS]);
  end

  // column sequencer: latch the lined-up item, then walk its columns
  rot_t                    rot_q_r;
  logic signed [FAC_W-1:0] fac_r [3];
  logic [2:0][POS_W-1:0]   pos_q_r;
  logic                    mode_q_r;
  logic                    act_r, act_nxt;
  logic [1:0]              col_r, col_nxt;
  logic [1:0]              last_col;
  logic [1:0]              col_sel;

  assign last_col = (mode_q_r == MODE_NORMAL) ? COL_LAST_NORMAL : COL_POS;
  assign col_sel  = (col_r == COL_POS) ? COL_LAST_NORMAL : col_r;

  always_comb begin
    act_nxt = act_r;
    col_nxt = col_r;
    if (align_v) begin
      act_nxt = 1'b1;
      col_nxt = 2'd0;
    end else if (act_r) begin
      if (col_r == last_col) begin
        act_nxt = 1'b0;
      end else begin
        col_nxt = col_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r <= 1'b0;
      col_r <= 2'd0;
    end else begin
      act_r <= act_nxt;
      col_r <= col_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (align_v) begin
      rot_q_r  <= rot_a;
      mode_q_r <= ctx_a.mode;
      pos_q_r  <= ctx_a.pos;
      for (int k = 0; k < 3; k++) begin
        fac_r[k] <= (ctx_a.mode == MODE_NORMAL) ? $signed(recip[k])
                                                : FAC_W'($signed(ctx_a.scale[k]));
      end
    end
  end

  // product stage: one column of three products per cycle
  logic                     pv_r;
  logic [1:0]               pcol_r;
  logic                     plast_r;
  logic                     pmode_r;
  logic signed [PROD_W-1:0] prod_r [3];
  logic [2:0][POS_W-1:0]    ppos_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r <= 1'b0;
    end else begin
      pv_r <= act_r;
    end
  end

  always_ff @(posedge clk) begin
    pcol_r  <= col_r;
    plast_r <= (col_r == last_col);
    pmode_r <= mode_q_r;
    ppos_r  <= pos_q_r;
    for (int r = 0; r < 3; r++) begin
      prod_r[r] <= $signed(rot_q_r[col_sel][r]) * $signed(fac_r[col_sel]);
    end
  end

  // output stage: scale back, saturate, or pass the position column
  function automatic logic [ENTRY_W-1:0] sat_entry(input logic signed [PROD_W-1:0] v);
    logic [PROD_W-ENTRY_W:0] top;
    logic [ENTRY_W-1:0]      r;
    top = v[PROD_W-1:ENTRY_W-1];
    if ((&top) || !(|top)) begin
      r = v[ENTRY_W-1:0];
    end else begin
      r = v[PROD_W-1] ? ENTRY_MIN : ENTRY_MAX;
    end
    return r;
  endfunction

  logic                     out_valid_r;
  logic [1:0]               out_col_r;
  logic                     out_last_r;
  logic [3:0][ENTRY_W-1:0]  out_e_r, out_e_nxt;
  logic signed [PROD_W-1:0] shifted [3];

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      shifted[r] = (pmode_r == MODE_NORMAL) ? (prod_r[r] >>> TRIG_FRAC)
                                            : (prod_r[r] >>> MODEL_SH);
    end
    if (pcol_r == COL_POS) begin
      out_e_nxt[0] = ppos_r[0];
      out_e_nxt[1] = ppos_r[1];
      out_e_nxt[2] = ppos_r[2];
      out_e_nxt[3] = W_ONE;
    end else begin
      out_e_nxt[0] = sat_entry(shifted[0]);
      out_e_nxt[1] = sat_entry(shifted[1]);
      out_e_nxt[2] = sat_entry(shifted[2]);
      out_e_nxt[3] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= pv_r;
    end
  end

  always_ff @(posedge clk) begin
    out_col_r  <= pcol_r;
    out_last_r <= plast_r;
    out_e_r    <= out_e_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_column_index = out_col_r;
  assign out_last_column  = out_last_r;
  assign out_entry_0      = $signed(out_e_r[0]);
  assign out_entry_1      = $signed(out_e_r[1]);
  assign out_entry_2      = $signed(out_e_r[2]);
  assign out_entry_3      = $signed(out_e_r[3]);

`ifndef SYNTHESIS
  a_gap_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy) else $error("busy not raised after input transfer");
  a_columns_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last_column |=> out_valid) else $error("gap inside an item's columns");
  a_pos_column_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_column_index == COL_POS |-> out_last_column && out_entry_3 == W_ONE)
    else $error("position column malformed");
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    align_v |-> !act_r || col_r == last_col) else $error("new item arrived mid-matrix");
`endif

endmodule
`default_nettype wire

// ===== dv/euler_transform_matrix_checker.sv =====
// column checker for the euler transform matrix core: predicts matrix columns per transfer
// depends on etm_pkg for widths and the mode encoding
`timescale 1ns / 100ps
module euler_transform_matrix_checker import etm_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic                      busy,
  input  logic                      in_mode,
  input  logic [15:0]               in_angle_x,
  input  logic [15:0]               in_angle_y,
  input  logic [15:0]               in_angle_z,
  input  logic signed [SCALE_W-1:0] in_scale_x,
  input  logic signed [SCALE_W-1:0] in_scale_y,
  input  logic signed [SCALE_W-1:0] in_scale_z,
  input  logic signed [POS_W-1:0]   in_pos_x,
  input  logic signed [POS_W-1:0]   in_pos_y,
  input  logic signed [POS_W-1:0]   in_pos_z,
  input  logic                      out_valid,
  input  logic [1:0]                out_column_index,
  input  logic signed [31:0]        out_entry_0,
  input  logic signed [31:0]        out_entry_1,
  input  logic signed [31:0]        out_entry_2,
  input  logic signed [31:0]        out_entry_3,
  input  logic                      out_last_column,
  output int                        fail_count,
  output int                        columns_pending
);

  typedef struct {
    logic [1:0]         idx;
    logic signed [31:0] e[4];
    logic               last;
  } column_t;

  column_t column_q[$];

  function automatic longint sat_entry(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint qmul(longint a, longint b);
    return (a * b) >>> 30;
  endfunction

  function automatic longint sine_q30(logic [15:0] ang);
    longint unsigned x, x2, t;
    logic [1:0] quad;
    quad = ang[15:14];
    x = longint'(ang[13:0]) << 16;
    if (quad[0]) x = (64'd1 << 30) - x;
    x2 = (x * x) >> 30;
    t = (64'd76016977 * x2) >> 30;
    t = 64'd688904866 - t;
    t = (t * x2) >> 30;
    t = 64'd1686629713 - t;
    t = (t * x) >> 30;
    return quad[1] ? -longint'(t) : longint'(t);
  endfunction

  function automatic longint cosine_q30(logic [15:0] ang);
    return sine_q30(ang + 16'h4000);
  endfunction

  function automatic longint scale_recip(longint s);
    if (s == 0) return 64'sd2147483647;
    return sat_entry((64'sd1 << 24) / s);
  endfunction

  task automatic predict_matrix();
    longint c1, s1, c2, s2, c3, s3, p12, q12, inv;
    longint rot[3][3];
    longint sc[3];
    longint pos[3];
    column_t col;
    int ncol;
    c2 = cosine_q30(in_angle_x); s2 = sine_q30(in_angle_x);
    c1 = cosine_q30(in_angle_y); s1 = sine_q30(in_angle_y);
    c3 = cosine_q30(in_angle_z); s3 = sine_q30(in_angle_z);
    sc[0] = in_scale_x; sc[1] = in_scale_y; sc[2] = in_scale_z;
    pos[0] = in_pos_x; pos[1] = in_pos_y; pos[2] = in_pos_z;
    p12 = qmul(s1, s2);
    q12 = qmul(c1, s2);
    rot[0][0] = qmul(c1, c3) + qmul(p12, s3);
    rot[0][1] = qmul(c2, s3);
    rot[0][2] = qmul(q12, s3) - qmul(c3, s1);
    rot[1][0] = qmul(p12, c3) - qmul(c1, s3);
    rot[1][1] = qmul(c2, c3);
    rot[1][2] = qmul(q12, c3) + qmul(s1, s3);
    rot[2][0] = qmul(c2, s1);
    rot[2][1] = -s2;
    rot[2][2] = qmul(c1, c2);
    ncol = (in_mode == MODE_NORMAL) ? 3 : 4;
    for (int k = 0; k < ncol; k++) begin
      col.idx = k[1:0];
      col.last = (k == ncol - 1);
      if (k == 3) begin
        for (int r = 0; r < 3; r++) col.e[r] = 32'(pos[r]);
        col.e[3] = 32'sd65536;
      end else begin
        inv = scale_recip(sc[k]);
        for (int r = 0; r < 3; r++) begin
          if (in_mode == MODE_NORMAL) col.e[r] = 32'(sat_entry((rot[k][r] * inv) >>> 30));
          else col.e[r] = 32'(sat_entry((rot[k][r] * sc[k]) >>> 22));
        end
        col.e[3] = 0;
      end
      column_q.push_back(col);
    end
  endtask

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
    fail_count++;
  endtask

  initial fail_count = 0;
  assign columns_pending = column_q.size();

  always @(posedge clk) begin
    column_t want;
    logic signed [31:0] got[4];
    if (rst_n && start && !busy) predict_matrix();
    if (rst_n && out_valid) begin
      if (column_q.size() == 0) begin
        report_mismatch("unexpected column", out_column_index, -1);
      end else begin
        want = column_q.pop_front();
        got[0] = out_entry_0; got[1] = out_entry_1;
        got[2] = out_entry_2; got[3] = out_entry_3;
        if (out_column_index !== want.idx)
          report_mismatch("column_index", out_column_index, want.idx);
        for (int r = 0; r < 4; r++)
          if (got[r] !== want.e[r])
            report_mismatch($sformatf("col %0d entry_%0d", want.idx, r), got[r], want.e[r]);
        if (out_last_column !== want.last)
          report_mismatch("last_column", out_last_column, want.last);
      end
    end
  end

endmodule

// ===== dv/euler_transform_matrix_core_tb.sv =====
// testbench top for the euler transform matrix core: stimulus, reset and verdict
// depends on etm_pkg, euler_transform_matrix_core and euler_transform_matrix_checker
`timescale 1ns / 100ps
module euler_transform_matrix_core_tb import etm_pkg::*;;

  localparam int RANDOM_ITEMS = 360;
  localparam int DRAIN_CYCLES = 60;
  localparam int STALL_LIMIT  = 400;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic in_mode = 1'b0;
  logic [15:0] in_angle_x = '0, in_angle_y = '0, in_angle_z = '0;
  logic signed [15:0] in_scale_x = '0, in_scale_y = '0, in_scale_z = '0;
  logic signed [31:0] in_pos_x = '0, in_pos_y = '0, in_pos_z = '0;
  logic out_valid, out_last_column;
  logic [1:0] out_column_index;
  logic signed [31:0] out_entry_0, out_entry_1, out_entry_2, out_entry_3;
  int fail_count, columns_pending;
  int idle_cycles = 0;

  always #5 clk = ~clk;

  euler_transform_matrix_core u_dut (.*);
  euler_transform_matrix_checker u_checker (.*);

  // watchdog: cycles with no transfer on either side
  always @(posedge clk) begin
    if (start && !busy || out_valid) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > STALL_LIMIT) begin
      $display("** euler_transform_matrix_core: FAILED **");
      $finish;
    end
  end

  // drive one item and hold it until the block takes it
  task automatic send_item(logic m, logic [15:0] ax, ay, az,
                           logic [15:0] sx, sy, sz, logic [31:0] px, py, pz);
    in_mode <= m;
    in_angle_x <= ax; in_angle_y <= ay; in_angle_z <= az;
    in_scale_x <= sx; in_scale_y <= sy; in_scale_z <= sz;
    in_pos_x <= px; in_pos_y <= py; in_pos_z <= pz;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // random gap burst between transfers
  task automatic maybe_gap(bit allow);
    int n;
    if (allow && $urandom_range(0, 3) == 0) begin
      n = $urandom_range(1, 17);
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  function automatic logic [15:0] pick_angle();
    case ($urandom_range(0, 3))
      0: return 16'(16'h4000 * $urandom_range(0, 3) + $urandom_range(0, 2) - 1);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_scale();
    case ($urandom_range(0, 5))
      0: return 16'h0000;
      1: return $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
      2: return $urandom_range(0, 1) ? 16'h0001 : 16'hffff;
      3: return 16'sd256 * $signed(16'($urandom_range(0, 8))) - 16'sd1024;
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    logic [15:0] edge_scale[6];
    int drain;
    edge_scale = '{16'h0000, 16'h0001, 16'hffff, 16'h7fff, 16'h8000, 16'h0100};
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // directed: quadrant corners, scale extremes incl zero, both modes, position extremes
    for (int i = 0; i < 12; i++)
      send_item(i[0], 16'h4000 * i[1:0], 16'hffff - 16'h4000 * i[2:1], 16'h2000 * i[3:0],
                edge_scale[i % 6], edge_scale[(i + 2) % 6], edge_scale[(i + 4) % 6],
                32'h7fff_ffff, 32'h8000_0000, i[0] ? 32'hffff_ffff : 32'h0);
    send_item(1'b0, 16'hffff, 16'hffff, 16'hffff, 16'h7fff, 16'h7fff, 16'h7fff,
              32'h0, 32'h1, 32'h0001_0000);
    send_item(1'b1, 16'h0, 16'h0, 16'h0, 16'h0001, 16'h0001, 16'h0001, 0, 0, 0);
    send_item(1'b1, 16'h2000, 16'h6000, 16'ha000, 16'hffff, 16'h8000, 16'h0000, 0, 0, 0);
    // random traffic, gaps only in the first part
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      maybe_gap(i < RANDOM_ITEMS - 60);
      send_item(1'($urandom_range(0, 1)), pick_angle(), pick_angle(), pick_angle(),
                pick_scale(), pick_scale(), pick_scale(), $urandom, $urandom, $urandom);
    end
    start <= 1'b0;
    drain = 0;
    while (columns_pending != 0 && drain < 2000) begin
      @(posedge clk);
      drain++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && columns_pending == 0) begin
      $display("** euler_transform_matrix_core: PASSED **");
    end else begin
      $display("** euler_transform_matrix_core: FAILED **");
    end
    $finish;
  end

endmodule
